[rtl/escape_time_fractal_iterator_defines.svh]
// assertion macros for the escape-time fractal iterator
// no dependencies
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define ETF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ETF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ETF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ETF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/etf_pkg.sv]
// shared types and constants for the escape-time fractal iterator
// no dependencies
`timescale 1ns / 1ps
package etf_pkg;
    localparam int CNT_W = 14;
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_SPECIES = 3'd0;
    localparam logic [IDX_W-1:0] REG_BAILOUT = 3'd1;
    localparam logic [IDX_W-1:0] REG_JULIA_RE = 3'd2;
    localparam logic [IDX_W-1:0] REG_JULIA_IM = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAX_ITER = 3'd4;
    localparam int BAIL_W = 37;

    typedef struct packed {
        logic signed [47:0] c_re;
        logic signed [47:0] c_im;
    } in_t;

    typedef struct packed {
        logic [CNT_W-1:0]   iteration_count;
        logic signed [47:0] z_re_final;
        logic signed [47:0] z_im_final;
    } out_t;

    // datapath micro-operations
    localparam logic [3:0] OP_LOAD  = 4'd0;
    localparam logic [3:0] OP_BO2   = 4'd1;
    localparam logic [3:0] OP_SR    = 4'd2;
    localparam logic [3:0] OP_SI    = 4'd3;
    localparam logic [3:0] OP_WI    = 4'd4;
    localparam logic [3:0] OP_WR    = 4'd5;
    localparam logic [3:0] OP_TR    = 4'd6;
    localparam logic [3:0] OP_TI    = 4'd7;
    localparam logic [3:0] OP_P3A   = 4'd8;
    localparam logic [3:0] OP_P3B   = 4'd9;
    localparam logic [3:0] OP_P4I   = 4'd10;
    localparam logic [3:0] OP_UPD   = 4'd11;
    localparam logic [3:0] OP_NONE  = 4'd12;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] power;
        logic [1:0] phase;
    } cmd_t;

    typedef struct packed {
        logic escaped;
    } sts_t;
endpackage

[rtl/etf_datapath.sv]
// datapath: z registers, shared saturating multiplier and adder
// depends on etf_pkg
`timescale 1ns / 1ps
module etf_datapath #(
    parameter int WORD_BITS = 48,
    parameter int FRAC_BITS = 32
) (
    input  logic                  clk,
    input  etf_pkg::cmd_t         cmd,
    input  logic signed [WORD_BITS-1:0] c_re,
    input  logic signed [WORD_BITS-1:0] c_im,
    input  logic signed [WORD_BITS-1:0] k_re,
    input  logic signed [WORD_BITS-1:0] k_im,
    input  logic [etf_pkg::BAIL_W-1:0]  bailout,
    output etf_pkg::sts_t         sts,
    output logic signed [WORD_BITS-1:0] z_re,
    output logic signed [WORD_BITS-1:0] z_im
);
    localparam int W = WORD_BITS;
    localparam int H = (W + 1) / 2;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] zr_reg, zi_reg, sr_reg, si_reg, wr_reg, wi_reg;
    logic signed [W-1:0] tr_reg, ti_reg, nr_reg, ni_reg, bo2_reg;
    logic signed [W-1:0] zr_next, zi_next, sr_next, si_next, wr_next, wi_next;
    logic signed [W-1:0] tr_next, ti_next, nr_next, ni_next, bo2_next;
    logic                esc_reg, esc_next;

    logic signed [W-1:0] ma, mb, mres;
    logic                msh1, mlast;
    logic [W-1:0]        bo_word, am, bm;
    logic [2*H-1:0]      amx, bmx, pp;
    logic [H-1:0]        pa, pb;
    logic [2*W-1:0]      acc_reg, acc_next, prod;

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                     input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
            return s[W] ? WMIN : WMAX;
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                     input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1])
            return s[W] ? WMIN : WMAX;
        return s[W-1:0];
    endfunction

    // magnitude product over four half-width slices, one per phase
    always_comb
    begin
        am = ma[W-1] ? W'(-ma) : ma;
        bm = mb[W-1] ? W'(-mb) : mb;
        amx = (2*H)'(am);
        bmx = (2*H)'(bm);
        pa = cmd.phase[1] ? amx[2*H-1:H] : amx[H-1:0];
        pb = cmd.phase[0] ? bmx[2*H-1:H] : bmx[H-1:0];
        pp = (2*H)'(pa) * (2*H)'(pb);
        unique case (cmd.phase)
            2'd0:       prod = (2*W)'(pp);
            2'd1, 2'd2: prod = (2*W)'(pp) << H;
            default:    prod = (2*W)'(pp) << (2*H);
        endcase
        acc_next = (cmd.phase == 2'd0) ? prod : acc_reg + prod;
        mlast = (cmd.phase == 2'd3);
    end

    // truncate, saturate
    always_comb
    begin
        logic          neg;
        logic [2*W-1:0] p, m;
        neg = ma[W-1] ^ mb[W-1];
        p = acc_next;
        m = msh1 ? (p >> (FRAC_BITS - 1)) : (p >> FRAC_BITS);
        if (neg)
        begin
            if (m > (2*W)'({1'b1, {(W-1){1'b0}}}))
                mres = WMIN;
            else
                mres = W'(-m);
        end
        else
        begin
            if (m > (2*W)'(WMAX))
                mres = WMAX;
            else
                mres = m[W-1:0];
        end
    end

    always_comb
    begin
        bo_word = (bailout == '0) ? W'(64'd4 << FRAC_BITS) : W'(bailout);
        ma = zr_reg;
        mb = zr_reg;
        msh1 = 1'b0;
        unique case (cmd.op)
            etf_pkg::OP_BO2: begin ma = bo_word; mb = bo_word; end
            etf_pkg::OP_SR:  begin ma = zr_reg; mb = zr_reg; end
            etf_pkg::OP_SI:  begin ma = zi_reg; mb = zi_reg; end
            etf_pkg::OP_WI:  begin ma = zr_reg; mb = zi_reg; msh1 = 1'b1; end
            etf_pkg::OP_TR:
            begin
                ma = wr_reg;
                mb = (cmd.power == 2'd3) ? zr_reg : wr_reg;
            end
            etf_pkg::OP_TI:
            begin
                ma = wi_reg;
                mb = (cmd.power == 2'd3) ? zi_reg : wi_reg;
            end
            etf_pkg::OP_P3A: begin ma = wr_reg; mb = zi_reg; end
            etf_pkg::OP_P3B: begin ma = zr_reg; mb = wi_reg; end
            etf_pkg::OP_P4I: begin ma = wr_reg; mb = wi_reg; msh1 = 1'b1; end
            default: ;
        endcase
    end

    always_comb
    begin
        zr_next = zr_reg; zi_next = zi_reg; sr_next = sr_reg; si_next = si_reg;
        wr_next = wr_reg; wi_next = wi_reg; tr_next = tr_reg; ti_next = ti_reg;
        nr_next = nr_reg; ni_next = ni_reg; bo2_next = bo2_reg; esc_next = esc_reg;
        unique case (cmd.op)
            etf_pkg::OP_LOAD: begin zr_next = c_re; zi_next = c_im; end
            etf_pkg::OP_BO2:  if (mlast) bo2_next = mres;
            etf_pkg::OP_SR:   if (mlast) sr_next = mres;
            etf_pkg::OP_SI:   if (mlast) si_next = mres;
            etf_pkg::OP_WI:   if (mlast) wi_next = mres;
            etf_pkg::OP_WR:
            begin
                wr_next = sat_sub(sr_reg, si_reg);
                tr_next = sr_reg;
                ti_next = si_reg;
                nr_next = sat_sub(sr_reg, si_reg);
                ni_next = wi_reg;
            end
            etf_pkg::OP_TR:   if (mlast) tr_next = mres;
            etf_pkg::OP_TI:
            begin
                if (mlast)
                begin
                    ti_next = mres;
                    nr_next = sat_sub(tr_reg, mres);
                end
            end
            etf_pkg::OP_P3A:  if (mlast) ni_next = mres;
            etf_pkg::OP_P3B:  if (mlast) ni_next = sat_add(ni_reg, mres);
            etf_pkg::OP_P4I:  if (mlast) ni_next = mres;
            etf_pkg::OP_UPD:
            begin
                zr_next = sat_add(nr_reg, k_re);
                zi_next = sat_add(ni_reg, k_im);
                esc_next = sat_add(tr_reg, ti_reg) > bo2_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        zr_reg <= zr_next; zi_reg <= zi_next; sr_reg <= sr_next; si_reg <= si_next;
        wr_reg <= wr_next; wi_reg <= wi_next; tr_reg <= tr_next; ti_reg <= ti_next;
        nr_reg <= nr_next; ni_reg <= ni_next; bo2_reg <= bo2_next; esc_reg <= esc_next;
        acc_reg <= acc_next;
    end

    assign sts.escaped = esc_reg;
    assign z_re = zr_reg;
    assign z_im = zi_reg;
endmodule

[rtl/etf_ctrl.sv]
// controller: sequences micro-operations and counts iterations
// depends on etf_pkg
`timescale 1ns / 1ps
module etf_ctrl #(
    parameter int ITER_LIMIT = 10000
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [2:0]                 species,
    input  logic [etf_pkg::CNT_W-1:0]  max_iterations,
    input  etf_pkg::sts_t              sts,
    output etf_pkg::cmd_t              cmd,
    output logic                       busy,
    output logic                       julia,
    output logic                       done,
    output logic [etf_pkg::CNT_W-1:0]  count
);
    localparam logic [3:0] S_IDLE = 4'd0, S_BO2 = 4'd1, S_SR = 4'd2, S_SI = 4'd3,
        S_WI = 4'd4, S_WR = 4'd5, S_TR = 4'd6, S_TI = 4'd7, S_P3A = 4'd8,
        S_P3B = 4'd9, S_P4I = 4'd10, S_UPD = 4'd11, S_CHK = 4'd12;

    logic [3:0]               state_reg, state_next;
    logic [1:0]               pow_reg, pow_next;
    logic [1:0]               ph_reg, ph_next;
    logic                     jul_reg, jul_next;
    logic [etf_pkg::CNT_W-1:0] n_reg, n_next, lim_reg, lim_next;
    logic                     done_reg, done_next;
    logic [2:0]               sp;
    logic                     mul_op;

    always_comb
    begin
        sp = (species > 3'd5) ? 3'd0 : species;
        state_next = state_reg; pow_next = pow_reg; jul_next = jul_reg;
        n_next = n_reg; lim_next = lim_reg; done_next = 1'b0;
        ph_next = 2'd0;
        cmd.power = pow_reg;
        cmd.phase = ph_reg;
        cmd.op = etf_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !done_reg)
                begin
                    cmd.op = etf_pkg::OP_LOAD;
                    pow_next = 2'(sp[2:1]) + 2'd2;
                    jul_next = sp[0];
                    n_next = '0;
                    if (max_iterations == '0)
                        lim_next = 14'd1;
                    else if (32'(max_iterations) > ITER_LIMIT)
                        lim_next = 14'(ITER_LIMIT);
                    else
                        lim_next = max_iterations;
                    state_next = S_BO2;
                end
            end
            S_BO2: begin cmd.op = etf_pkg::OP_BO2; state_next = S_SR; end
            S_SR:  begin cmd.op = etf_pkg::OP_SR;  state_next = S_SI; end
            S_SI:  begin cmd.op = etf_pkg::OP_SI;  state_next = S_WI; end
            S_WI:  begin cmd.op = etf_pkg::OP_WI;  state_next = S_WR; end
            S_WR:
            begin
                cmd.op = etf_pkg::OP_WR;
                state_next = (pow_reg == 2'd2) ? S_UPD : S_TR;
            end
            S_TR:  begin cmd.op = etf_pkg::OP_TR;  state_next = S_TI; end
            S_TI:
            begin
                cmd.op = etf_pkg::OP_TI;
                state_next = (pow_reg == 2'd3) ? S_P3A : S_P4I;
            end
            S_P3A: begin cmd.op = etf_pkg::OP_P3A; state_next = S_P3B; end
            S_P3B: begin cmd.op = etf_pkg::OP_P3B; state_next = S_UPD; end
            S_P4I: begin cmd.op = etf_pkg::OP_P4I; state_next = S_UPD; end
            S_UPD: begin cmd.op = etf_pkg::OP_UPD; state_next = S_CHK; end
            S_CHK:
            begin
                if (sts.escaped || (n_reg + 14'd1 >= lim_reg))
                begin
                    if (!sts.escaped)
                        n_next = n_reg + 14'd1;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    n_next = n_reg + 14'd1;
                    state_next = S_SR;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // products take four phases
        mul_op = (cmd.op == etf_pkg::OP_BO2) || (cmd.op == etf_pkg::OP_SR)
              || (cmd.op == etf_pkg::OP_SI) || (cmd.op == etf_pkg::OP_WI)
              || (cmd.op == etf_pkg::OP_TR) || (cmd.op == etf_pkg::OP_TI)
              || (cmd.op == etf_pkg::OP_P3A) || (cmd.op == etf_pkg::OP_P3B)
              || (cmd.op == etf_pkg::OP_P4I);
        if (mul_op && (ph_reg != 2'd3))
        begin
            state_next = state_reg;
            ph_next = ph_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            pow_reg   <= 2'd2;
            ph_reg    <= 2'd0;
            jul_reg   <= 1'b0;
            n_reg     <= '0;
            lim_reg   <= 14'd1;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            pow_reg   <= pow_next;
            ph_reg    <= ph_next;
            jul_reg   <= jul_next;
            n_reg     <= n_next;
            lim_reg   <= lim_next;
        end
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign julia = jul_reg;
    assign done = done_reg;
    assign count = n_reg;
endmodule

[rtl/escape_time_fractal_iterator.sv]
// escape-time fractal iterator: Mandelbrot / Julia, powers 2 to 4
// top level; depends on etf_pkg, etf_ctrl, etf_datapath and the defines header
//
// usage: a point is taken on the clock edge where start is high and busy low.
// configuration is written through cfg_valid / cfg_ready / cfg_index /
// cfg_data; the user must write it only while the block is idle, which the
// block itself does not enforce; cfg_ready is always high. one half-width
// multiplier slice is shared by all products, and bailout squared is
// computed once per point. done pulses for one cycle with the result
// transaction and the receiver cannot stall it. busy covers that cycle, so
// the next point is taken in the cycle after done.
// reset returns the registers to species 0, bailout 4.0, the default Julia
// constant and 20 iterations, and drops any point in flight.
`timescale 1ns / 1ps
`include "escape_time_fractal_iterator_defines.svh"
module escape_time_fractal_iterator #(
    parameter int ITER_LIMIT = 10000
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  etf_pkg::in_t          in_data,
    output logic                  done,
    output etf_pkg::out_t         out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [etf_pkg::IDX_W-1:0] cfg_index,
    input  logic [63:0]           cfg_data
);
    logic [2:0]                       species_reg;
    logic [etf_pkg::BAIL_W-1:0]       bailout_reg;
    logic signed [47:0]               jre_reg, jim_reg;
    logic [etf_pkg::CNT_W-1:0]        maxit_reg;
    etf_pkg::cmd_t                    cmd;
    etf_pkg::sts_t                    sts;
    logic                             julia;
    logic signed [47:0]               z_re, z_im, k_re, k_im;
    logic [etf_pkg::CNT_W-1:0]        count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            species_reg <= 3'd0;
            bailout_reg <= 37'd17179869184;
            jre_reg     <= 48'sd1667125916;
            jim_reg     <= -48'sd536870912;
            maxit_reg   <= 14'd20;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                etf_pkg::REG_SPECIES:  species_reg <= cfg_data[2:0];
                etf_pkg::REG_BAILOUT:  bailout_reg <= cfg_data[36:0];
                etf_pkg::REG_JULIA_RE: jre_reg <= cfg_data[47:0];
                etf_pkg::REG_JULIA_IM: jim_reg <= cfg_data[47:0];
                etf_pkg::REG_MAX_ITER: maxit_reg <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // julia constant or the point itself, held in the z load cycle
    logic signed [47:0] cre_reg, cim_reg;
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cre_reg <= in_data.c_re;
            cim_reg <= in_data.c_im;
        end
    end
    assign k_re = julia ? jre_reg : cre_reg;
    assign k_im = julia ? jim_reg : cim_reg;

    etf_ctrl #(.ITER_LIMIT(ITER_LIMIT)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .species(species_reg),
        .max_iterations(maxit_reg), .sts(sts), .cmd(cmd), .busy(busy),
        .julia(julia), .done(done), .count(count)
    );

    etf_datapath #(.WORD_BITS(48), .FRAC_BITS(32)) u_dp (
        .clk(clk), .cmd(cmd), .c_re(in_data.c_re), .c_im(in_data.c_im),
        .k_re(k_re), .k_im(k_im), .bailout(bailout_reg), .sts(sts),
        .z_re(z_re), .z_im(z_im)
    );

    assign out_data.iteration_count = count;
    assign out_data.z_re_final = z_re;
    assign out_data.z_im_final = z_im;

    `ETF_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ETF_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done)
    `ETF_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy)
endmodule
